>>> design/gradient_noise_turbulence_assert.svh
// ----------------------------------------------------------------------------
// gradient_noise_turbulence assertion macros
// Shared concurrent assertion forms for the noise block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_TURBULENCE_ASSERT_SVH
`define GRADIENT_NOISE_TURBULENCE_ASSERT_SVH

// same-cycle implication
`define GNT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gnt assertion failed");

// next-cycle implication
`define GNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gnt assertion failed");

`endif

>>> design/gnt_pkg.sv
// ----------------------------------------------------------------------------
// gnt_pkg
// Types and constants shared by the gradient noise controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gnt_pkg;

	localparam int TABLE_SIZE_DEF = 256;
	localparam int MAX_OCT_DEF    = 8;

	localparam int        DEPTH_W   = 4;
	localparam logic [3:0] DEPTH_RST = 4'd7;

	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int W_W     = 17;  // Q1.16 weight up to 1.0
	localparam int D_W     = 17;  // signed offset
	localparam int PROD_W  = 33;
	localparam int DOT_W   = 35;
	localparam int WD_W    = 53;
	localparam int SUM_W   = 56;
	localparam int ACC_W   = 60;
	localparam int OUT_W   = 32;

	localparam logic [W_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [1:0] MODE_LOAD_GRAD = 2'd0;
	localparam logic [1:0] MODE_LOAD_PERM = 2'd1;
	localparam logic [1:0] MODE_NOISE     = 2'd2;
	localparam logic [1:0] MODE_TURB      = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SQUARE,
		ST_SMOOTH,
		ST_CORNER,
		ST_DRAIN,
		ST_ACCUM,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       wr_grad;
		logic       wr_perm;
		logic       clr_sum;
		logic       shift_en;
		logic       square_en;
		logic       smooth_en;
		logic       issue;
		logic [2:0] corner;
		logic       clr_acc;
		logic       acc_en;
		logic       load_out;
		logic       eval;
		logic       turb;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} sts_t;

endpackage

`default_nettype wire

>>> design/gnt_datapath.sv
// ----------------------------------------------------------------------------
// gnt_datapath
// Table memories, per-octave smoothstep setup, corner pipeline and accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module gnt_datapath #(
	parameter int TABLE_SIZE  = gnt_pkg::TABLE_SIZE_DEF,
	parameter int MAX_OCTAVES = gnt_pkg::MAX_OCT_DEF,
	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1,
	localparam int OCT_W = $clog2(MAX_OCTAVES + 1)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  gnt_pkg::cmd_t           cmd,
	input  wire [OCT_W-1:0]         oct,
	output gnt_pkg::sts_t           sts,
	input  wire [7:0]               table_index,
	input  wire signed [15:0]       grad_x,
	input  wire signed [15:0]       grad_y,
	input  wire signed [15:0]       grad_z,
	input  wire [7:0]               perm_for_x,
	input  wire [7:0]               perm_for_y,
	input  wire [7:0]               perm_for_z,
	input  wire signed [31:0]       coord_x,
	input  wire signed [31:0]       coord_y,
	input  wire signed [31:0]       coord_z,
	output logic signed [31:0]      noise_value,
	output logic                    is_evaluation
);

	localparam int W_W   = gnt_pkg::W_W;
	localparam int D_W   = gnt_pkg::D_W;
	localparam int SH_W  = 48;

	logic [47:0]      grad_mem [TABLE_SIZE];
	logic [7:0]       permx_mem [TABLE_SIZE];
	logic [7:0]       permy_mem [TABLE_SIZE];
	logic [7:0]       permz_mem [TABLE_SIZE];

	logic [IDX_W-1:0] widx;
	assign widx = IDX_W'(table_index);

	always_ff @(posedge clk) begin
		if (cmd.wr_grad) begin
			grad_mem[widx] <= {grad_x, grad_y, grad_z};
		end
		if (cmd.wr_perm) begin
			permx_mem[widx] <= perm_for_x;
			permy_mem[widx] <= perm_for_y;
			permz_mem[widx] <= perm_for_z;
		end
	end

	// per-axis setup registers
	logic signed [31:0] coord_q [3];
	logic [IDX_W-1:0]   cell_q  [3];
	logic [15:0]        frac_q  [3];
	logic [31:0]        ff_q    [3];
	logic [W_W-1:0]     s_q     [3];

	logic [SH_W-1:0]    shifted [3];
	logic [49:0]        smooth_p [3];
	logic [17:0]        smooth_k [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			shifted[a]  = {{16{coord_q[a][31]}}, coord_q[a]} << oct;
			smooth_k[a] = 18'd196608 - {1'b0, frac_q[a], 1'b0};
			smooth_p[a] = 50'(ff_q[a]) * 50'(smooth_k[a]) + 50'(64'h8000_0000);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			coord_q[0] <= coord_x;
			coord_q[1] <= coord_y;
			coord_q[2] <= coord_z;
		end
		for (int a = 0; a < 3; a++) begin
			if (cmd.shift_en) begin
				cell_q[a] <= shifted[a][16 +: IDX_W];
				frac_q[a] <= shifted[a][15:0];
			end
			if (cmd.square_en) begin
				ff_q[a] <= 32'(frac_q[a]) * 32'(frac_q[a]);
			end
			if (cmd.smooth_en) begin
				s_q[a] <= smooth_p[a][48:32];
			end
		end
	end

	// corner pipeline
	logic [2:0]               sel;
	logic [IDX_W-1:0]         addr [3];
	assign sel = {cmd.corner[0], cmd.corner[1], cmd.corner[2]};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			addr[a] = cell_q[a] + IDX_W'(sel[2-a]);
		end
	end

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [7:0]               px_s1, py_s1, pz_s1;
	logic [W_W-1:0]           wx_s1, wy_s1, wz_s1;
	logic signed [D_W-1:0]    d_s1 [3];
	logic [47:0]              g_s2;
	logic [W_W-1:0]           wxy_s2, wz_s2;
	logic signed [D_W-1:0]    d_s2 [3];
	logic signed [gnt_pkg::PROD_W-1:0] p_s3 [3];
	logic [W_W-1:0]           w_s3, w_s4;
	logic signed [gnt_pkg::DOT_W-1:0]  dot_s4;
	logic signed [gnt_pkg::WD_W-1:0]   wd_s5;
	logic signed [gnt_pkg::SUM_W-1:0]  sum_q;

	logic [IDX_W-1:0]         hash;
	logic [33:0]              wxy_p, w_p;
	logic signed [15:0]       g_c [3];

	assign hash  = IDX_W'(px_s1 ^ py_s1 ^ pz_s1);
	assign wxy_p = 34'(wx_s1) * 34'(wy_s1) + 34'd32768;
	assign w_p   = 34'(wxy_s2) * 34'(wz_s2) + 34'd32768;
	assign g_c[0] = g_s2[47:32];
	assign g_c[1] = g_s2[31:16];
	assign g_c[2] = g_s2[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= permx_mem[addr[0]];
		py_s1 <= permy_mem[addr[1]];
		pz_s1 <= permz_mem[addr[2]];
		wx_s1 <= sel[2] ? s_q[0] : W_W'(gnt_pkg::ONE_Q16 - s_q[0]);
		wy_s1 <= sel[1] ? s_q[1] : W_W'(gnt_pkg::ONE_Q16 - s_q[1]);
		wz_s1 <= sel[0] ? s_q[2] : W_W'(gnt_pkg::ONE_Q16 - s_q[2]);
		for (int a = 0; a < 3; a++) begin
			d_s1[a] <= {sel[2-a], frac_q[a]};  // f - 1.0 when the upper corner
			d_s2[a] <= d_s1[a];
			p_s3[a] <= gnt_pkg::PROD_W'(g_c[a]) * gnt_pkg::PROD_W'(d_s2[a]);
		end
		g_s2   <= grad_mem[hash];
		wxy_s2 <= wxy_p[32:16];
		wz_s2  <= wz_s1;
		w_s3   <= w_p[32:16];
		dot_s4 <= gnt_pkg::DOT_W'(p_s3[0]) + gnt_pkg::DOT_W'(p_s3[1])
			+ gnt_pkg::DOT_W'(p_s3[2]);
		w_s4   <= w_s3;
		wd_s5  <= gnt_pkg::WD_W'($signed({1'b0, w_s4})) * gnt_pkg::WD_W'(dot_s4);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_sum) begin
			sum_q <= '0;
		end else if (v_s5) begin
			sum_q <= sum_q + gnt_pkg::SUM_W'(wd_s5);
		end
	end

	assign sts.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

	// octave accumulation with round half up
	logic signed [gnt_pkg::ACC_W-1:0] acc_q;
	logic signed [gnt_pkg::ACC_W-1:0] half, rs;

	always_comb begin
		half = (oct == '0) ? '0 : (gnt_pkg::ACC_W'(1) << (oct - OCT_W'(1)));
		rs   = (gnt_pkg::ACC_W'(sum_q) + half) >>> oct;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + rs;
		end
	end

	// final rounding to 28 fraction bits, optional magnitude, saturation
	logic signed [gnt_pkg::ACC_W-1:0] fin_t, fin_r;
	logic signed [31:0]               fin;

	always_comb begin
		fin_t = (acc_q + gnt_pkg::ACC_W'(64'sd262144)) >>> 19;
		fin_r = (cmd.turb && fin_t < 0) ? -fin_t : fin_t;
		if (fin_r > gnt_pkg::ACC_W'(64'sd2147483647)) begin
			fin = 32'sh7fff_ffff;
		end else if (fin_r < gnt_pkg::ACC_W'(-64'sd2147483648)) begin
			fin = 32'sh8000_0000;
		end else begin
			fin = fin_r[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			noise_value   <= cmd.eval ? fin : '0;
			is_evaluation <= cmd.eval;
		end
	end

endmodule

`default_nettype wire

>>> design/gnt_ctrl.sv
// ----------------------------------------------------------------------------
// gnt_ctrl
// Sequencer: handshakes, depth register, octave and corner counting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gradient_noise_turbulence_assert.svh"

module gnt_ctrl #(
	parameter int MAX_OCTAVES = gnt_pkg::MAX_OCT_DEF,
	localparam int OCT_W = $clog2(MAX_OCTAVES + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire [1:0]           mode,
	output logic                out_valid,
	input  wire                 out_stall,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [3:0]           cfg_data,
	output gnt_pkg::cmd_t       cmd,
	output logic [OCT_W-1:0]    oct,
	input  gnt_pkg::sts_t       sts
);

	gnt_pkg::state_t  state_q, state_d;
	logic [3:0]       depth_q;
	logic [OCT_W-1:0] oct_q, oct_d, n_q, n_d;
	logic [2:0]       corner_q, corner_d;
	logic             eval_q, eval_d, turb_q, turb_d;
	logic             out_valid_q, out_free, accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != gnt_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign oct       = oct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gnt_pkg::ST_IDLE;
			depth_q     <= gnt_pkg::DEPTH_RST;
			oct_q       <= '0;
			n_q         <= '0;
			corner_q    <= '0;
			eval_q      <= 1'b0;
			turb_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			oct_q    <= oct_d;
			n_q      <= n_d;
			corner_q <= corner_d;
			eval_q   <= eval_d;
			turb_q   <= turb_d;
			if (cfg_valid && cfg_ready) begin
				depth_q <= cfg_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		oct_d    = oct_q;
		n_d      = n_q;
		corner_d = corner_q;
		eval_d   = eval_q;
		turb_d   = turb_q;
		cmd      = '0;
		cmd.corner = corner_q;
		cmd.eval   = eval_q;
		cmd.turb   = turb_q;
		unique case (state_q)
			gnt_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					cmd.clr_acc = 1'b1;
					oct_d       = '0;
					turb_d      = (mode == gnt_pkg::MODE_TURB);
					unique case (mode)
						gnt_pkg::MODE_LOAD_GRAD: begin
							cmd.wr_grad = 1'b1;
							eval_d      = 1'b0;
							state_d     = gnt_pkg::ST_RESULT;
						end
						gnt_pkg::MODE_LOAD_PERM: begin
							cmd.wr_perm = 1'b1;
							eval_d      = 1'b0;
							state_d     = gnt_pkg::ST_RESULT;
						end
						gnt_pkg::MODE_NOISE: begin
							eval_d  = 1'b1;
							n_d     = OCT_W'(1);
							state_d = gnt_pkg::ST_SHIFT;
						end
						default: begin
							eval_d = 1'b1;
							if (32'(depth_q) > MAX_OCTAVES) begin
								n_d = OCT_W'(MAX_OCTAVES);
							end else begin
								n_d = OCT_W'(depth_q);
							end
							state_d = (depth_q == '0) ? gnt_pkg::ST_RESULT
								: gnt_pkg::ST_SHIFT;
						end
					endcase
				end
			end
			gnt_pkg::ST_SHIFT: begin
				cmd.shift_en = 1'b1;
				cmd.clr_sum  = 1'b1;
				state_d      = gnt_pkg::ST_SQUARE;
			end
			gnt_pkg::ST_SQUARE: begin
				cmd.square_en = 1'b1;
				state_d       = gnt_pkg::ST_SMOOTH;
			end
			gnt_pkg::ST_SMOOTH: begin
				cmd.smooth_en = 1'b1;
				corner_d      = '0;
				state_d       = gnt_pkg::ST_CORNER;
			end
			gnt_pkg::ST_CORNER: begin
				cmd.issue = 1'b1;
				corner_d  = corner_q + 3'd1;
				if (corner_q == 3'd7) begin
					state_d = gnt_pkg::ST_DRAIN;
				end
			end
			gnt_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = gnt_pkg::ST_ACCUM;
				end
			end
			gnt_pkg::ST_ACCUM: begin
				cmd.acc_en = 1'b1;
				oct_d      = oct_q + OCT_W'(1);
				state_d    = (oct_q + OCT_W'(1) == n_q) ? gnt_pkg::ST_RESULT
					: gnt_pkg::ST_SHIFT;
			end
			gnt_pkg::ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = gnt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gnt_pkg::ST_IDLE;
			end
		endcase
	end

	`GNT_ASSERT_SAME(a_idle_pipe_empty, clk, arst_n, state_q == gnt_pkg::ST_IDLE, !sts.pipe_busy)
	`GNT_ASSERT_SAME(a_accum_after_drain, clk, arst_n, cmd.acc_en, !sts.pipe_busy)
	`GNT_ASSERT_NEXT(a_load_shows_word, clk, arst_n, cmd.load_out, out_valid_q)

endmodule

`default_nettype wire

>>> design/gradient_noise_turbulence.sv
// ----------------------------------------------------------------------------
// gradient_noise_turbulence
// 3D gradient noise and turbulence over loaded gradient/permutation tables.
// ----------------------------------------------------------------------------
//  channel | handshake         | word
//  in      | in_valid/in_stall | mode, table_index, grad_*, perm_for_*, coord_*
//  out     | out_valid/out_stall | noise_value, is_evaluation
//  cfg     | cfg_valid/cfg_ready | cfg_data (turb_depth)
//
// Loads: accept, then result. Each octave runs in steps:
// 3 setup, 8 corner issues (one gradient fetch and dot product each), drain
// until the pipeline is empty, 1 accumulate.
// in_stall is high from accept until the result reaches the output register.
// Reset clears control only; the tables hold garbage until written.
// A finished word waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_turbulence #(
	parameter int TABLE_SIZE  = gnt_pkg::TABLE_SIZE_DEF,
	parameter int MAX_OCTAVES = gnt_pkg::MAX_OCT_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [1:0]          mode,
	input  wire [7:0]          table_index,
	input  wire signed [15:0]  grad_x,
	input  wire signed [15:0]  grad_y,
	input  wire signed [15:0]  grad_z,
	input  wire [7:0]          perm_for_x,
	input  wire [7:0]          perm_for_y,
	input  wire [7:0]          perm_for_z,
	input  wire signed [31:0]  coord_x,
	input  wire signed [31:0]  coord_y,
	input  wire signed [31:0]  coord_z,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] noise_value,
	output logic               is_evaluation,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [3:0]          cfg_data
);

	localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

	gnt_pkg::cmd_t    cmd;
	gnt_pkg::sts_t    sts;
	logic [OCT_W-1:0] oct;

	gnt_ctrl #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.oct       (oct),
		.sts       (sts)
	);

	gnt_datapath #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.oct          (oct),
		.sts          (sts),
		.table_index  (table_index),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.grad_z       (grad_z),
		.perm_for_x   (perm_for_x),
		.perm_for_y   (perm_for_y),
		.perm_for_z   (perm_for_z),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.noise_value  (noise_value),
		.is_evaluation(is_evaluation)
	);

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// gradient_noise_turbulence testbench
// Fills the gradient and permutation tables, then runs directed and random
// noise and turbulence words against an in-bench fixed-point predictor, with
// random idling on both channels and several octave depth settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         mode;
	logic [7:0]         table_index;
	logic signed [15:0] grad_x, grad_y, grad_z;
	logic [7:0]         perm_for_x, perm_for_y, perm_for_z;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] noise_value;
	logic               is_evaluation;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_data;

	bit quiet;       // no idling in the last part of the run
	int idle_cycles; // cycles with nothing accepted

	gradient_noise_turbulence dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .table_index(table_index),
		.grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.perm_for_x(perm_for_x), .perm_for_y(perm_for_y), .perm_for_z(perm_for_z),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.noise_value(noise_value), .is_evaluation(is_evaluation),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	class noise_scoreboard;
		logic signed [15:0] grad_tab [256][3];
		logic [7:0]         perm_tab [256][3];
		logic [3:0]         depth = gnt_pkg::DEPTH_RST;
		logic signed [31:0] exp_value [$];
		logic               exp_eval  [$];
		int                 errors = 0;

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		function longint round_down(longint v, int sh);
			if (sh == 0) begin
				return v;
			end
			return (v + (longint'(1) << (sh - 1))) >>> sh;
		endfunction

		// weighted corner sum, Q.47, for the point scaled by 2^oct
		function longint octave_total(longint c [3], int oct);
			longint unsigned u, f [3], s [3], wx, wy, wz, wxy, w;
			logic [7:0] cell_ix [3];
			logic [7:0] h;
			longint dot, acc;
			acc = 0;
			for (int a = 0; a < 3; a++) begin
				u = longint'(c[a]) << oct;
				cell_ix[a] = u[23:16];
				f[a] = {48'd0, u[15:0]};
				s[a] = (f[a] * f[a] * (64'd196608 - 64'd2 * f[a]) + (64'd1 << 31)) >> 32;
			end
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++)
					for (int k = 0; k < 2; k++) begin
						h = perm_tab[8'(cell_ix[0] + i)][0] ^ perm_tab[8'(cell_ix[1] + j)][1]
							^ perm_tab[8'(cell_ix[2] + k)][2];
						wx = i ? s[0] : 64'd65536 - s[0];
						wy = j ? s[1] : 64'd65536 - s[1];
						wz = k ? s[2] : 64'd65536 - s[2];
						wxy = (wx * wy + 64'd32768) >> 16;
						w = (wxy * wz + 64'd32768) >> 16;
						dot = longint'(grad_tab[h][0]) * (longint'(f[0]) - i * 65536)
							+ longint'(grad_tab[h][1]) * (longint'(f[1]) - j * 65536)
							+ longint'(grad_tab[h][2]) * (longint'(f[2]) - k * 65536);
						acc += longint'(w) * dot;
					end
			return acc;
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) begin
				return 32'h7fffffff;
			end
			if (v < -64'sd2147483648) begin
				return 32'h80000000;
			end
			return v[31:0];
		endfunction

		function void note_word(logic [1:0] m, logic [7:0] ti, logic signed [15:0] gx,
			logic signed [15:0] gy, logic signed [15:0] gz, logic [7:0] px, logic [7:0] py,
			logic [7:0] pz, logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cz);
			longint c [3];
			longint acc, r;
			int n;
			c[0] = cx;
			c[1] = cy;
			c[2] = cz;
			case (m)
				gnt_pkg::MODE_LOAD_GRAD: begin
					grad_tab[ti][0] = gx;
					grad_tab[ti][1] = gy;
					grad_tab[ti][2] = gz;
					exp_value.push_back(0);
					exp_eval.push_back(1'b0);
				end
				gnt_pkg::MODE_LOAD_PERM: begin
					perm_tab[ti][0] = px;
					perm_tab[ti][1] = py;
					perm_tab[ti][2] = pz;
					exp_value.push_back(0);
					exp_eval.push_back(1'b0);
				end
				gnt_pkg::MODE_NOISE: begin
					exp_value.push_back(clamp32(round_down(octave_total(c, 0), 19)));
					exp_eval.push_back(1'b1);
				end
				default: begin
					n = (depth > gnt_pkg::MAX_OCT_DEF) ? gnt_pkg::MAX_OCT_DEF : int'(depth);
					acc = 0;
					for (int o = 0; o < n; o++)
						acc += round_down(octave_total(c, o), o);
					r = round_down(acc, 19);
					if (r < 0) begin
						r = -r;
					end
					exp_value.push_back(clamp32(r));
					exp_eval.push_back(1'b1);
				end
			endcase
		endfunction

		task check_word(logic signed [31:0] v, logic e);
			logic signed [31:0] ev;
			logic ee;
			if (exp_value.size() == 0) begin
				report($sformatf("unexpected word value %0d eval %0b", v, e));
				return;
			end
			ev = exp_value.pop_front();
			ee = exp_eval.pop_front();
			if (v !== ev) begin
				report($sformatf("noise_value %0d, expected %0d", v, ev));
			end
			if (e !== ee) begin
				report($sformatf("is_evaluation %0b, expected %0b", e, ee));
			end
		endtask
	endclass

	noise_scoreboard sb;

	always #4 clk = ~clk;

	// receiver: check accepted words, stall in bursts
	int stall_left, run_left;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_word(noise_value, is_evaluation);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && run_left == 0 && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				if (run_left > 0) begin
					run_left--;
				end else if ($urandom_range(0, 15) == 0) begin
					run_left = $urandom_range(20, 120);
				end
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 5000) begin
			$display("gradient_noise_turbulence verification failed");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] m, logic [7:0] ti, logic signed [15:0] gx,
		logic signed [15:0] gy, logic signed [15:0] gz, logic [7:0] px, logic [7:0] py,
		logic [7:0] pz, logic signed [31:0] cx, logic signed [31:0] cy,
		logic signed [31:0] cz);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		table_index <= ti;
		grad_x <= gx;
		grad_y <= gy;
		grad_z <= gz;
		perm_for_x <= px;
		perm_for_y <= py;
		perm_for_z <= pz;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_word(m, ti, gx, gy, gz, px, py, pz, cx, cy, cz);
	endtask

	task automatic send_point(logic [1:0] m, logic signed [31:0] cx, logic signed [31:0] cy,
		logic signed [31:0] cz);
		send_word(m, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), cx, cy, cz);
	endtask

	// permutation values stay below 64, so only gradients 0 to 63 are fetched
	task automatic send_random();
		int pick;
		logic [31:0] c [3];
		pick = $urandom_range(0, 99);
		for (int a = 0; a < 3; a++) begin
			case ($urandom_range(0, 3))
				0: c[a] = $urandom;
				1: c[a] = {{16{1'b0}}, 16'($urandom)};
				2: c[a] = {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
				default: c[a] = {{16{1'b1}}, 16'($urandom)};
			endcase
		end
		if (pick < 15)
			send_word(gnt_pkg::MODE_LOAD_GRAD, 8'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				$urandom, $urandom, $urandom);
		else if (pick < 30)
			send_word(gnt_pkg::MODE_LOAD_PERM, 8'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
				8'($urandom_range(0, 63)), $urandom, $urandom, $urandom);
		else if (pick < 70)
			send_point(gnt_pkg::MODE_NOISE, c[0], c[1], c[2]);
		else
			send_point(gnt_pkg::MODE_TURB, c[0], c[1], c[2]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.exp_value.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_depth(logic [3:0] d);
		wait_drained();
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.depth = d;
	endtask

	initial begin
		logic [3:0] depths [5];
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mode = '0;
		table_index = '0;
		{grad_x, grad_y, grad_z} = '0;
		{perm_for_x, perm_for_y, perm_for_z} = '0;
		{coord_x, coord_y, coord_z} = '0;
		quiet = 1'b0;
		idle_cycles = 0;
		stall_left = 0;
		run_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry that a hash can reach is written before any evaluation
		for (int i = 0; i < 64; i++) begin
			case (i)
				0: send_word(gnt_pkg::MODE_LOAD_GRAD, 8'(i), 16'sh7fff, 16'sh7fff, 16'sh7fff,
					0, 0, 0, 0, 0, 0);
				1: send_word(gnt_pkg::MODE_LOAD_GRAD, 8'(i), 16'sh8000, 16'sh8000, 16'sh8000,
					0, 0, 0, 0, 0, 0);
				default: send_word(gnt_pkg::MODE_LOAD_GRAD, 8'(i), 16'($urandom),
					16'($urandom), 16'($urandom), 0, 0, 0, 0, 0, 0);
			endcase
		end
		for (int i = 0; i < 256; i++)
			send_word(gnt_pkg::MODE_LOAD_PERM, 8'(i), 0, 0, 0, 8'($urandom_range(0, 63)),
				8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)), 0, 0, 0);

		// directed points: extremes, lattice points, fractions near one
		send_point(gnt_pkg::MODE_NOISE, 0, 0, 0);
		send_point(gnt_pkg::MODE_NOISE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_point(gnt_pkg::MODE_NOISE, 32'h80000000, 32'h80000000, 32'h80000000);
		send_point(gnt_pkg::MODE_NOISE, 32'h0000ffff, 32'h00008000, 32'hffff0001);
		send_point(gnt_pkg::MODE_NOISE, 32'hffffffff, 32'h00010000, 32'h00ff8000);
		send_point(gnt_pkg::MODE_TURB, 32'h00018000, 32'h00024000, 32'h0003c000);
		send_point(gnt_pkg::MODE_TURB, 32'h7fffffff, 32'h80000000, 32'hffffffff);
		send_word(gnt_pkg::MODE_LOAD_PERM, 8'hff, 0, 0, 0, 8'h3f, 8'h00, 8'h3f, 0, 0, 0);
		send_word(gnt_pkg::MODE_LOAD_GRAD, 8'h3f, 16'sh8000, 16'sh7fff, 16'sh8000,
			0, 0, 0, 0, 0, 0);
		send_point(gnt_pkg::MODE_NOISE, 32'h00ff7fff, 32'h00ff7fff, 32'h00ff7fff);

		// depth zero, above the octave limit, both ends of the legal range
		depths = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9};
		foreach (depths[d]) begin
			write_depth(depths[d]);
			send_point(gnt_pkg::MODE_TURB, 32'h0001c000, 32'hfffe4000, 32'h7fff0000);
			send_point(gnt_pkg::MODE_TURB, 32'h00008001, 32'h80007fff, 32'h00000001);
		end

		for (int p = 0; p < 6; p++) begin
			write_depth(p == 0 ? gnt_pkg::DEPTH_RST : 4'($urandom));
			for (int n = 0; n < 20; n++) begin
				if (p == 5 && n == 5) begin
					quiet = 1'b1;
				end
				if (p == 2 && n == 10) begin
					wait_drained();
				end
				send_random();
			end
		end
		in_valid <= 1'b0;

		while (sb.exp_value.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.exp_value.size() == 0)
			$display("gradient_noise_turbulence verification clean");
		else
			$display("gradient_noise_turbulence verification failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/gnt_pkg.sv
design/gnt_datapath.sv
design/gnt_ctrl.sv
design/gradient_noise_turbulence.sv
test/testbench.sv
